@@ hdl/vsrd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsrd_pkg
// Shared types and constants of the vsync rate stability detector.
// ----------------------------------------------------------------------------
package vsrd_pkg;

  localparam int RING_DEPTH_DEF = 128;

  localparam int TS_W    = 64;
  localparam int IVL_W   = 20;
  localparam int GAME_W  = 18;
  localparam int CNT_W   = 11;
  localparam int DRIFT_W = 10;
  localparam int RATE_W  = 20;
  localparam int SUM_W   = 32;
  localparam int SQ_W    = 64;
  localparam int CFG_W   = 20;
  localparam int CIDX_W  = 3;

  localparam logic [CNT_W-1:0]  CNT_MAX  = 11'd2047;
  localparam logic [63:0]       RATE_MAX = 64'd1000000;
  localparam logic [63:0]       NS_SCALE = 64'd1000000000;
  localparam logic [31:0]       PCT_MUL  = 32'd100;

  localparam logic [GAME_W-1:0]  GAME_RST  = 18'd60000;
  localparam logic [IVL_W-1:0]   MIN_RST   = 20'd8334;
  localparam logic [IVL_W-1:0]   MAX_RST   = 20'd20000;
  localparam logic [CNT_W-1:0]   MINS_RST  = 11'd60;
  localparam logic [CNT_W-1:0]   TOUT_RST  = 11'd1800;
  localparam logic [DRIFT_W-1:0] DRIFT_RST = 10'd300;

  localparam logic [CIDX_W-1:0] REG_GAME  = 3'd0;
  localparam logic [CIDX_W-1:0] REG_MIN   = 3'd1;
  localparam logic [CIDX_W-1:0] REG_MAX   = 3'd2;
  localparam logic [CIDX_W-1:0] REG_MINS  = 3'd3;
  localparam logic [CIDX_W-1:0] REG_TOUT  = 3'd4;
  localparam logic [CIDX_W-1:0] REG_DRIFT = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SUM_RD,
    ST_SUM_MX,
    ST_NQ,
    ST_SS,
    ST_L,
    ST_R,
    ST_A,
    ST_DIV,
    ST_B,
    ST_D,
    ST_OUT
  } st_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_st_t;

endpackage

@@ hdl/vsrd_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsrd_mul
// Shared 64x32 multiplier, one 32x32 partial product per cycle.
// ----------------------------------------------------------------------------
module vsrd_mul (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [63:0]         a,
  input  logic [31:0]         b,
  output logic [95:0]         p,
  output vsrd_pkg::mul_st_t   st
);
  import vsrd_pkg::*;

  logic        ph_r;
  logic        done_r;
  logic [63:0] pl_r;
  logic [95:0] p_r;
  logic [31:0] mop;
  logic [63:0] m;

  assign mop = ph_r ? a[63:32] : a[31:0];
  assign m   = mop * b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= ph_r;
      if (start) begin
        ph_r <= 1'b1;
      end else begin
        ph_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      pl_r <= m;
    end
    if (ph_r) begin
      p_r <= {m, 32'd0} + {32'd0, pl_r};
    end
  end

  assign p       = p_r;
  assign st.busy = ph_r;
  assign st.done = done_r;

  always_ff @(posedge clk) begin
    if (rst_n) begin
      assert (!(start && ph_r)) else $error("multiplier started while busy");
    end
  end

endmodule

@@ hdl/vsync_rate_stability_detector_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsync_rate_stability_detector_unit
// Measures the display vsync rate and picks vsync or audio clock pacing.
//
// Input channel in_*: one microsecond vsync timestamp per transfer. Each
// transfer gives exactly one result transfer on out_*: sync mode, stable
// flag, measured rate in milli-Hz and whether the interval was stored.
// Config port cfg_*: writes take effect at once; write only while idle.
// A rejected or non-tested sample goes from the check state straight to
// the output state. A tested sample walks n = min(count, RING_DEPTH) ring
// entries through the shared multiplier, then up to seven products and a
// bit-serial divider. One item is in work at a time; in_ready is high only
// idle. The result sits in an output register, so a new item is taken while
// the receiver stalls; the next result waits until that register is free.
// Reset clears the control state and restores register defaults; the
// ring is not cleared, only written entries are ever read.
// ----------------------------------------------------------------------------
module vsync_rate_stability_detector_unit #(
  parameter int RING_DEPTH = vsrd_pkg::RING_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [vsrd_pkg::TS_W-1:0]     in_timestamp_us,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_sync_mode,
  output logic                          out_stable,
  output logic [vsrd_pkg::RATE_W-1:0]   out_measured_rate_millihz,
  output logic                          out_sample_accepted,
  input  logic                          cfg_we,
  input  logic [vsrd_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [vsrd_pkg::CFG_W-1:0]    cfg_wdata
);
  import vsrd_pkg::*;

  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int NW = $clog2(RING_DEPTH + 1);

  st_t st_r, st_nxt;

  logic [GAME_W-1:0]  game_r;
  logic [IVL_W-1:0]   min_r, max_r;
  logic [CNT_W-1:0]   mins_r, tout_r;
  logic [DRIFT_W-1:0] drift_r;

  logic [TS_W-1:0]    ts_r, last_r;
  logic [AW-1:0]      wp_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               done_r, mode_r, acc_r, job_drift_r, pass_r;
  logic [DRIFT_W-1:0] dc_r;
  logic [RATE_W-1:0]  rate_r;
  logic [NW-1:0]      n_r, tk_r, ridx_r;

  logic [IVL_W-1:0]   ring [RING_DEPTH];
  logic [IVL_W-1:0]   rdata_r;

  logic [SUM_W-1:0]   s_r;
  logic [SQ_W-1:0]    q_r, dv_r, ss_r, av_r, bv_r;
  logic [95:0]        lp_r;
  logic [63:0]        num_r;
  logic [31:0]        rem_r;
  logic [5:0]         dcnt_r;

  logic               out_valid_r, out_mode_r, out_stable_r, out_acc_r;
  logic [RATE_W-1:0]  out_rate_r;

  logic [TS_W-1:0]    intv;
  logic               reject, first;
  logic [CNT_W-1:0]   cnt_new;
  logic [DRIFT_W-1:0] dc_inc;
  logic               drift_hit, test_go;
  logic [31:0]        n32, k32;
  logic [63:0]        d2;
  logic               stable_c;
  logic [32:0]        dtry;
  logic               qbit;
  logic [63:0]        num_next;

  logic               mul_start, mem_rd, mul_op;
  logic [63:0]        mul_a;
  logic [31:0]        mul_b;
  logic [95:0]        mul_p;
  mul_st_t            mst;

  vsrd_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .p     (mul_p),
    .st    (mst)
  );

  assign intv    = ts_r - last_r;
  assign first   = (last_r == '0);
  assign reject  = (intv == '0) || (intv < {44'd0, min_r}) || (intv > {44'd0, max_r});
  assign cnt_new = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;
  assign dc_inc  = dc_r + 1'b1;
  assign drift_hit = mode_r && (dc_inc >= drift_r);
  assign test_go = done_r ? drift_hit : (cnt_new >= mins_r);

  assign n32 = 32'(n_r);
  assign k32 = (n32 << 13) + (n32 << 10) + (n32 << 9) + (n32 << 8) + (n32 << 4);
  assign d2  = (av_r > bv_r) ? av_r - bv_r : bv_r - av_r;
  assign stable_c = (n_r >= NW'(2)) && (lp_r < mul_p);

  assign dtry     = {rem_r, num_r[63]};
  assign qbit     = (dtry >= {1'b0, s_r});
  assign num_next = {num_r[62:0], qbit};

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:   if (in_valid) st_nxt = ST_CHECK;
      ST_CHECK: begin
        if (first || reject || !test_go) st_nxt = ST_OUT;
        else st_nxt = ST_SUM_RD;
      end
      ST_SUM_RD: st_nxt = ST_SUM_MX;
      ST_SUM_MX: begin
        if (mst.done && (tk_r + 1'b1 == n_r)) st_nxt = job_drift_r ? ST_A : ST_NQ;
      end
      ST_NQ:     if (mst.done) st_nxt = ST_SS;
      ST_SS:     if (mst.done) st_nxt = ST_L;
      ST_L:      if (mst.done) st_nxt = ST_R;
      ST_R: begin
        if (mst.done) st_nxt = (stable_c || (cnt_r >= tout_r)) ? ST_A : ST_OUT;
      end
      ST_A:      if (mst.done) st_nxt = job_drift_r ? ST_B : ST_DIV;
      ST_DIV: begin
        if (dcnt_r == 6'd63) st_nxt = pass_r ? ST_B : ST_OUT;
      end
      ST_B:      if (mst.done) st_nxt = ST_D;
      ST_D:      if (mst.done) st_nxt = ST_OUT;
      ST_OUT:    if (!out_valid_r || out_ready) st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  // operand select and unit control
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_op = 1'b1;
    unique case (st_r)
      ST_SUM_MX: begin
        mul_a = 64'(rdata_r);
        mul_b = 32'(rdata_r);
      end
      ST_NQ: begin
        mul_a = q_r;
        mul_b = n32;
      end
      ST_SS: begin
        mul_a = 64'(s_r);
        mul_b = s_r;
      end
      ST_L: begin
        mul_a = dv_r;
        mul_b = k32;
      end
      ST_R: begin
        mul_a = ss_r;
        mul_b = n32 - 32'd1;
      end
      ST_A: begin
        mul_a = NS_SCALE;
        mul_b = n32;
      end
      ST_B: begin
        mul_a = 64'(s_r);
        mul_b = 32'(game_r);
      end
      ST_D: begin
        mul_a = d2;
        mul_b = PCT_MUL;
      end
      default: mul_op = 1'b0;
    endcase
    mul_start = mul_op && !mst.busy && !mst.done;
    mem_rd    = (st_r == ST_SUM_RD) || ((st_r == ST_SUM_MX) && mst.busy);
  end

  assign in_ready = (st_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if ((st_r == ST_CHECK) && !first && !reject) begin
      ring[wp_r] <= intv[IVL_W-1:0];
    end
    if (mem_rd) begin
      rdata_r <= ring[ridx_r[AW-1:0]];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      game_r  <= GAME_RST;
      min_r   <= MIN_RST;
      max_r   <= MAX_RST;
      mins_r  <= MINS_RST;
      tout_r  <= TOUT_RST;
      drift_r <= DRIFT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAME:  game_r  <= cfg_wdata[GAME_W-1:0];
        REG_MIN:   min_r   <= cfg_wdata[IVL_W-1:0];
        REG_MAX:   max_r   <= cfg_wdata[IVL_W-1:0];
        REG_MINS:  mins_r  <= cfg_wdata[CNT_W-1:0];
        REG_TOUT:  tout_r  <= cfg_wdata[CNT_W-1:0];
        REG_DRIFT: drift_r <= cfg_wdata[DRIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      last_r      <= '0;
      wp_r        <= '0;
      cnt_r       <= '0;
      done_r      <= 1'b0;
      mode_r      <= 1'b0;
      dc_r        <= '0;
      rate_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if ((st_r == ST_OUT) && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        ST_CHECK: begin
          last_r <= ts_r;
          if (!first && !reject) begin
            wp_r  <= (wp_r == AW'(RING_DEPTH - 1)) ? '0 : wp_r + 1'b1;
            cnt_r <= cnt_new;
            if (done_r && mode_r) begin
              dc_r <= drift_hit ? '0 : dc_inc;
            end
          end
        end
        ST_DIV: begin
          if (dcnt_r == 6'd63) begin
            done_r <= 1'b1;
            rate_r <= (num_next > RATE_MAX) ? RATE_MAX[RATE_W-1:0] : num_next[RATE_W-1:0];
          end
        end
        ST_D: begin
          if (mst.done) begin
            if (job_drift_r) begin
              mode_r <= mode_r && (mul_p[63:0] < bv_r);
            end else begin
              mode_r <= mode_r || (mul_p[63:0] < bv_r);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ts_r <= in_timestamp_us;
    end
    if (mem_rd) begin
      ridx_r <= ridx_r + 1'b1;
    end
    unique case (st_r)
      ST_CHECK: begin
        acc_r       <= !first && !reject;
        job_drift_r <= done_r;
        pass_r      <= 1'b0;
        s_r         <= '0;
        q_r         <= '0;
        tk_r        <= '0;
        ridx_r      <= '0;
        if (32'(cnt_new) < 32'(RING_DEPTH)) begin
          n_r <= NW'(cnt_new);
        end else begin
          n_r <= NW'(RING_DEPTH);
        end
      end
      ST_SUM_MX: begin
        if (mul_start) s_r <= s_r + SUM_W'(rdata_r);
        if (mst.done) begin
          q_r  <= q_r + mul_p[63:0];
          tk_r <= tk_r + 1'b1;
        end
      end
      ST_NQ: if (mst.done) dv_r <= mul_p[63:0];
      ST_SS: begin
        if (mst.done) begin
          ss_r <= mul_p[63:0];
          dv_r <= dv_r - mul_p[63:0];
        end
      end
      ST_L: if (mst.done) lp_r <= mul_p;
      ST_R: if (mst.done) pass_r <= stable_c;
      ST_A: begin
        if (mst.done) begin
          av_r   <= mul_p[63:0];
          num_r  <= mul_p[63:0] + 64'(s_r >> 1);
          rem_r  <= '0;
          dcnt_r <= '0;
        end
      end
      ST_DIV: begin
        num_r  <= num_next;
        rem_r  <= qbit ? 32'(dtry - {1'b0, s_r}) : dtry[31:0];
        dcnt_r <= dcnt_r + 1'b1;
      end
      ST_B: if (mst.done) bv_r <= mul_p[63:0];
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_mode_r   <= mode_r;
          out_stable_r <= done_r;
          out_rate_r   <= done_r ? rate_r : '0;
          out_acc_r    <= acc_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid                 = out_valid_r;
  assign out_sync_mode             = out_mode_r;
  assign out_stable                = out_stable_r;
  assign out_measured_rate_millihz = out_rate_r;
  assign out_sample_accepted       = out_acc_r;

  a_mode_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r |-> done_r) else $error("vsync mode without finished measurement");

  a_rate_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {44'd0, rate_r} <= RATE_MAX) else $error("rate above saturation");

  a_done_from_div: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(done_r) |-> $past(st_r) == ST_DIV) else $error("stable set outside divider");

  a_start_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
    mul_start |-> !mst.busy && !mst.done) else $error("multiplier reissued");

endmodule
